// ----- hw/rtl/pca_projection_engine_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef PCA_PROJECTION_ENGINE_MACROS_SVH
`define PCA_PROJECTION_ENGINE_MACROS_SVH

// same-cycle implication
`define PCA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pca_pkg.sv -----
package pca_pkg;
  localparam int MAX_FEATURES   = 64;
  localparam int MAX_COMPONENTS = 16;
  localparam int FRAC_BITS      = 16;
  localparam int RSQRT_STEPS    = 4;
  localparam int FW             = $clog2(MAX_FEATURES);
  localparam int CW             = $clog2(MAX_COMPONENTS);
  localparam int WW             = FW + CW;

  localparam logic [2:0] OP_MEAN = 3'd0;
  localparam logic [2:0] OP_VAR  = 3'd1;
  localparam logic [2:0] OP_EIG  = 3'd2;
  localparam logic [2:0] OP_WGT  = 3'd3;
  localparam logic [2:0] OP_DATA = 3'd4;

  localparam logic [2:0] REG_CENTER = 3'd0;
  localparam logic [2:0] REG_SCALE  = 3'd1;
  localparam logic [2:0] REG_WHITEN = 3'd2;
  localparam logic [2:0] REG_NFEAT  = 3'd3;
  localparam logic [2:0] REG_NCOMP  = 3'd4;

  localparam logic [31:0] Q_MAX_U = 32'h7FFF_FFFF;

  typedef struct packed {
    logic        done;
    logic        flag;
    logic [31:0] root;
  } rsq_res_t;

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p);
    logic signed [63:0] u;
    u = p + (64'sd1 <<< (FRAC_BITS - 1));
    return u >>> FRAC_BITS;
  endfunction

  // {flag, clipped value}
  function automatic logic [32:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sh0000_0000_8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
    if (a[63] && b[63] && !s[63]) return {1'b1, {63{1'b0}}};
    return s;
  endfunction
endpackage

// ----- hw/rtl/pca_projection_engine.sv -----
// channel  | dir | handshake        | payload
// s_*      | in  | s_tvalid/tready  | tuser operation, tdata feature/component/value
// m_*      | out | m_tvalid/tready  | tdata component/projected, tlast row end, tuser sat
// cfg_*    | in  | cfg_valid/ready  | cfg_index register, cfg_data value
// Variance and eigenvalue loads run the Newton unit; a nonpositive value skips the
// iterations. A data item visits each component in use in turn (one shared multiplier).
// Row end emits one result per component in use, each held while m_tready is low.
// s_tready is low while an item is in progress; m_tready stalls the block.
// Synchronous reset clears the row accumulators; the stores need loading.
module pca_projection_engine import pca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // feature_index[5:0], component_index[9:6], value[41:10]
  input  logic [2:0]  s_tuser,  // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // out_component[3:0], projected[35:4]
  output logic        m_tlast,
  output logic        m_tuser,  // saturated[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_RSQ   = 4'd2;
  localparam logic [3:0] S_CTR   = 4'd3;
  localparam logic [3:0] S_SCM   = 4'd4;
  localparam logic [3:0] S_SCR   = 4'd5;
  localparam logic [3:0] S_WRD   = 4'd6;
  localparam logic [3:0] S_WMUL  = 4'd7;
  localparam logic [3:0] S_WACC  = 4'd8;
  localparam logic [3:0] S_ORD   = 4'd9;
  localparam logic [3:0] S_OCLP  = 4'd10;
  localparam logic [3:0] S_OMUL  = 4'd11;
  localparam logic [3:0] S_ORND  = 4'd12;
  localparam logic [3:0] S_OSEND = 4'd13;

  logic [3:0] state;
  logic center_en, scale_en, whiten_en;
  logic [6:0] nfeat_reg;
  logic [4:0] ncomp_reg;
  logic [6:0] nf;
  logic [CW-1:0] nc_m1;

  logic [2:0]         op;
  logic [FW-1:0]      fidx;
  logic [CW-1:0]      cidx;
  logic signed [31:0] val;
  logic signed [31:0] x;
  logic [CW-1:0]      j;
  logic [6:0]         rowpos;
  logic               rowsat;
  logic signed [63:0] acc [MAX_COMPONENTS];
  logic signed [63:0] prod;
  logic signed [32:0] ma, mb;
  logic signed [31:0] ov;
  logic               osat;

  logic [31:0] mean_q, wgt_q;
  logic [32:0] istd_q, eig_q;
  logic        rsq_start;
  rsq_res_t    rsq;
  logic [32:0] c_ctr, c_scr, c_acc, c_wht;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    if (nfeat_reg == 7'd0) nf = 7'd1;
    else if (nfeat_reg > 7'(MAX_FEATURES)) nf = 7'(MAX_FEATURES);
    else nf = nfeat_reg;
    if (ncomp_reg == 5'd0) nc_m1 = '0;
    else if (ncomp_reg > 5'(MAX_COMPONENTS)) nc_m1 = CW'(MAX_COMPONENTS - 1);
    else nc_m1 = CW'(ncomp_reg - 5'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_en <= 1'b0;
      scale_en  <= 1'b0;
      whiten_en <= 1'b0;
      nfeat_reg <= 7'd64;
      ncomp_reg <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER: center_en <= cfg_data[0];
        REG_SCALE:  scale_en  <= cfg_data[0];
        REG_WHITEN: whiten_en <= cfg_data[0];
        REG_NFEAT:  nfeat_reg <= cfg_data;
        REG_NCOMP:  ncomp_reg <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  pca_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_mean (
    .clk(clk), .we(state == S_DEC && op == OP_MEAN), .waddr(fidx),
    .wdata(val), .raddr(fidx), .rdata(mean_q));

  pca_ram #(.WIDTH(33), .DEPTH(MAX_FEATURES)) u_istd (
    .clk(clk), .we(state == S_RSQ && rsq.done && op == OP_VAR), .waddr(fidx),
    .wdata({rsq.flag, rsq.root}), .raddr(fidx), .rdata(istd_q));

  pca_ram #(.WIDTH(33), .DEPTH(MAX_COMPONENTS)) u_eig (
    .clk(clk), .we(state == S_RSQ && rsq.done && op == OP_EIG), .waddr(cidx),
    .wdata({rsq.flag, rsq.root}), .raddr(j), .rdata(eig_q));

  pca_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES * MAX_COMPONENTS)) u_wgt (
    .clk(clk), .we(state == S_DEC && op == OP_WGT), .waddr({cidx, fidx}),
    .wdata(val), .raddr({j, fidx}), .rdata(wgt_q));

  assign rsq_start = (state == S_DEC) && (op == OP_VAR || op == OP_EIG);

  pca_rsqrt u_rsqrt (
    .clk(clk), .rst(rst), .start(rsq_start), .value(val), .res(rsq));

  always_comb begin
    case (state)
      S_SCM:   begin ma = {x[31], x};   mb = {1'b0, istd_q[31:0]}; end
      S_OMUL:  begin ma = {ov[31], ov}; mb = {1'b0, eig_q[31:0]}; end
      default: begin ma = {x[31], x};   mb = {wgt_q[31], wgt_q}; end
    endcase
  end

  assign c_ctr = clip32(64'(val) - 64'(signed'(mean_q)));
  assign c_scr = clip32(round_shift(prod));
  assign c_acc = clip32(acc[j]);
  assign c_wht = clip32(round_shift(prod));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rowpos <= '0;
      rowsat <= 1'b0;
      j      <= '0;
      for (int i = 0; i < MAX_COMPONENTS; i++) acc[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            fidx  <= s_tdata[5:0];
            cidx  <= s_tdata[9:6];
            val   <= s_tdata[41:10];
            state <= S_DEC;
          end
        end
        S_DEC: begin
          case (op)
            OP_VAR, OP_EIG: state <= S_RSQ;
            OP_DATA:        state <= S_CTR;
            default:        state <= S_IDLE;
          endcase
        end
        S_RSQ: if (rsq.done) state <= S_IDLE;
        S_CTR: begin
          j <= '0;
          if (center_en) begin
            x <= c_ctr[31:0];
            if (c_ctr[32]) rowsat <= 1'b1;
          end else begin
            x <= val;
          end
          state <= scale_en ? S_SCM : S_WRD;
        end
        S_SCM: begin
          prod  <= 64'(ma * mb);
          state <= S_SCR;
        end
        S_SCR: begin
          x <= c_scr[31:0];
          if (c_scr[32] || istd_q[32]) rowsat <= 1'b1;
          state <= S_WRD;
        end
        S_WRD: state <= S_WMUL;
        S_WMUL: begin
          prod  <= 64'(ma * mb);
          state <= S_WACC;
        end
        S_WACC: begin
          acc[j] <= add_sat64(acc[j], round_shift(prod));
          if (j == nc_m1) begin
            j <= '0;
            if ({1'b0, rowpos} + 8'd1 < {1'b0, nf}) begin
              rowpos <= rowpos + 7'd1;
              state  <= S_IDLE;
            end else begin
              state <= S_ORD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_WRD;
          end
        end
        S_ORD: state <= S_OCLP;
        S_OCLP: begin
          ov    <= c_acc[31:0];
          osat  <= rowsat | c_acc[32];
          state <= whiten_en ? S_OMUL : S_OSEND;
        end
        S_OMUL: begin
          prod  <= 64'(ma * mb);
          state <= S_ORND;
        end
        S_ORND: begin
          ov <= c_wht[31:0];
          if (c_wht[32] || eig_q[32]) osat <= 1'b1;
          state <= S_OSEND;
        end
        S_OSEND: begin
          if (m_tready) begin
            if (j == nc_m1) begin
              // all components, also those above the count in use
              for (int i = 0; i < MAX_COMPONENTS; i++) acc[i] <= '0;
              j      <= '0;
              rowpos <= '0;
              rowsat <= 1'b0;
              state  <= S_IDLE;
            end else begin
              acc[j] <= '0;
              j      <= j + 1'b1;
              state  <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_OSEND);
  assign m_tdata  = {4'b0, ov, j};
  assign m_tlast  = (j == nc_m1);
  assign m_tuser  = osat;
endmodule

// ----- hw/rtl/pca_ram.sv -----
module pca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/pca_rsqrt.sv -----
module pca_rsqrt import pca_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] value,
  output rsq_res_t           res
);
  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_NORM = 3'd1;
  localparam logic [2:0] R_M0   = 3'd2;
  localparam logic [2:0] R_M1   = 3'd3;
  localparam logic [2:0] R_M2   = 3'd4;
  localparam logic [2:0] R_M3   = 3'd5;
  localparam logic [2:0] R_DONE = 3'd6;
  localparam int SW = $clog2(RSQRT_STEPS + 1);
  localparam logic [63:0] THREE = 64'd3 << FRAC_BITS;

  logic [2:0]    state;
  logic [30:0]   uv;
  logic [30:0]   sh;
  logic [5:0]    k;
  logic [30:0]   y;
  logic [63:0]   prod;
  logic [SW-1:0] step;
  logic          flag;
  logic [32:0]   ma;
  logic [63:0]   t_full;
  logic [32:0]   t_clip;
  logic [63:0]   m;
  logic [32:0]   d;
  logic [63:0]   ynew;
  logic [6:0]    s;

  assign t_full = prod >> FRAC_BITS;
  assign t_clip = (t_full > 64'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : t_full[32:0];
  assign m      = prod >> FRAC_BITS;
  assign d      = (m >= THREE) ? 33'd0 : 33'(THREE - m);
  assign ynew   = prod >> (FRAC_BITS + 1);
  assign s      = 7'(3 * FRAC_BITS) - {1'b0, k};

  always_comb begin
    case (state)
      R_M0:    ma = {2'b0, uv};
      R_M1:    ma = t_clip;
      default: ma = d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      flag  <= 1'b0;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            if (value <= 32'sd0) begin
              y     <= 31'h7FFF_FFFF;
              flag  <= 1'b1;
              state <= R_DONE;
            end else begin
              uv    <= value[30:0];
              sh    <= value[30:0];
              k     <= '0;
              step  <= '0;
              flag  <= 1'b0;
              state <= R_NORM;
            end
          end
        end
        R_NORM: begin
          if (sh != '0) begin
            sh <= sh >> 1;
            k  <= k + 6'd1;
          end else begin
            y     <= 31'd1 << s[6:1];
            state <= R_M0;
          end
        end
        R_M0, R_M1, R_M2: begin
          prod  <= 64'(ma * {2'b0, y});
          state <= state + 3'd1;
        end
        R_M3: begin
          y <= (ynew > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : ynew[30:0];
          if (step == SW'(RSQRT_STEPS - 1)) begin
            state <= R_DONE;
          end else begin
            step  <= step + 1'b1;
            state <= R_M0;
          end
        end
        R_DONE: begin
          if (y == 31'h7FFF_FFFF) flag <= 1'b1;
          state <= R_IDLE;
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  always_comb begin
    res.done = (state == R_DONE);
    res.flag = flag || (y == 31'h7FFF_FFFF);
    res.root = {1'b0, y};
  end
endmodule

// ----- hw/rtl/pca_checker.sv -----
`include "pca_projection_engine_macros.svh"

module pca_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  `PCA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `PCA_ASSERT_NOW(a_no_overlap, clk, rst, m_tvalid, !s_tready, "input taken while result pending")
  `PCA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "ready right after an item")
  `PCA_ASSERT_NEXT(a_gap_after_last, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after row end")
endmodule

bind pca_projection_engine pca_checker u_pca_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pca_pkg::*;

  localparam int LIMIT = 1000000;
  localparam int SETTLE = 300;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  feat;
    logic [3:0]  comp;
    logic [31:0] val;
  } load_item_t;

  typedef struct packed {
    logic [3:0]  comp;
    logic [31:0] proj;
    logic        last;
    logic        sat;
  } proj_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  pca_projection_engine u_dut (.*);

  // predictor state
  logic signed [31:0] mean_mem [MAX_FEATURES];
  logic [31:0]        istd_mem [MAX_FEATURES];
  bit                 istd_flag [MAX_FEATURES];
  logic [31:0]        ieig_mem [MAX_COMPONENTS];
  bit                 ieig_flag [MAX_COMPONENTS];
  logic signed [31:0] wgt_mem [MAX_COMPONENTS*MAX_FEATURES];
  logic signed [63:0] acc [MAX_COMPONENTS];
  int unsigned        row_pos;
  bit                 row_sat;
  bit                 cen, scl, wht;
  logic [6:0]         nfeat;
  logic [4:0]         ncomp;

  load_item_t pend_q[$];
  proj_t      proj_q[$];
  int         err_cnt, row_cnt, res_cnt, load_cnt, data_cnt, cyc;
  int         gap;
  bit         s_took, bursty;
  int         fset[8] = '{0, 1, 2, 3, 4, 5, 40, 63};
  int         cfgs[6][5] = '{
    '{1, 1, 1, 4, 16}, '{0, 0, 0, 1, 1}, '{1, 0, 1, 64, 16},
    '{0, 1, 0, 5, 7}, '{1, 1, 1, 0, 0}, '{1, 1, 0, 127, 31}};

  initial forever #6 clk = ~clk;

  function automatic logic signed [63:0] q_round(logic signed [63:0] p);
    logic signed [63:0] u;
    u = p + 64'sd32768;
    return u >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] q_clip(logic signed [63:0] v, inout bit f);
    if (v > 64'sd2147483647) begin
      f = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] acc_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
    if (a[63] && b[63] && !s[63]) return {1'b1, 63'd0};
    return s;
  endfunction

  function automatic logic [31:0] inv_root(logic signed [31:0] v, output bit f);
    logic [63:0] uv, y, t, m, d;
    int k, s;
    f = 0;
    if (v <= 0) begin
      f = 1;
      return 32'h7FFF_FFFF;
    end
    uv = 64'(v);
    k = 0;
    while (k < 32 && (uv >> k) != 0) k++;
    s = 3 * FRAC_BITS - k;
    if (s < 0) y = 0;
    else if (s / 2 >= 31) y = 64'h7FFF_FFFF;
    else y = 64'd1 << (s / 2);
    for (int i = 0; i < RSQRT_STEPS; i++) begin
      t = (uv * y) >> FRAC_BITS;
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      m = (t * y) >> FRAC_BITS;
      d = (m >= (64'd3 << FRAC_BITS)) ? 64'd0 : (64'd3 << FRAC_BITS) - m;
      y = (y * d) >> (FRAC_BITS + 1);
      if (y > 64'h7FFF_FFFF) y = 64'h7FFF_FFFF;
    end
    if (y >= 64'h7FFF_FFFF) f = 1;
    return y[31:0];
  endfunction

  task automatic clear_row();
    for (int j = 0; j < MAX_COMPONENTS; j++) acc[j] = 0;
    row_pos = 0;
    row_sat = 0;
  endtask

  task automatic project_item(load_item_t it);
    int nf, nc, fi;
    bit f, sat;
    logic signed [63:0] x, v;
    proj_t r;
    nf = (nfeat < 1) ? 1 : (nfeat > MAX_FEATURES) ? MAX_FEATURES : nfeat;
    nc = (ncomp < 1) ? 1 : (ncomp > MAX_COMPONENTS) ? MAX_COMPONENTS : ncomp;
    fi = it.feat;
    case (it.op)
      OP_MEAN: mean_mem[fi] = it.val;
      OP_VAR: istd_mem[fi] = inv_root(it.val, istd_flag[fi]);
      OP_EIG: ieig_mem[it.comp] = inv_root(it.val, ieig_flag[it.comp]);
      OP_WGT: wgt_mem[it.comp * MAX_FEATURES + fi] = it.val;
      default: ;
    endcase
    if (it.op != OP_DATA) return;
    f = 0;
    x = 64'(signed'(it.val));
    if (cen) x = q_clip(x - 64'(mean_mem[fi]), f);
    if (scl) begin
      x = q_clip(q_round(x * $signed({32'd0, istd_mem[fi]})), f);
      if (istd_flag[fi]) f = 1;
    end
    if (f) row_sat = 1;
    for (int j = 0; j < nc; j++)
      acc[j] = acc_add(acc[j], q_round(x * 64'(wgt_mem[j * MAX_FEATURES + fi])));
    if (row_pos + 1 < nf) begin
      row_pos = (row_pos + 1) & 7'h7F;
      return;
    end
    for (int j = 0; j < nc; j++) begin
      sat = row_sat;
      v = q_clip(acc[j], sat);
      if (wht) begin
        v = q_clip(q_round(v * $signed({32'd0, ieig_mem[j]})), sat);
        if (ieig_flag[j]) sat = 1;
      end
      r.comp = j[3:0];
      r.proj = v[31:0];
      r.last = (j + 1 == nc);
      r.sat = sat;
      proj_q.push_back(r);
    end
    row_cnt++;
    clear_row();
  endtask

  task automatic report(string what);
    $display("mismatch @%0d: %s", cyc, what);
    err_cnt++;
  endtask

  // monitor: sample at rising edge
  always @(posedge clk) begin
    proj_t e;
    cyc++;
    if (cyc > LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      s_took <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER: cen = cfg_data[0];
          REG_SCALE: scl = cfg_data[0];
          REG_WHITEN: wht = cfg_data[0];
          REG_NFEAT: nfeat = cfg_data;
          REG_NCOMP: ncomp = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        project_item('{s_tuser, s_tdata[5:0], s_tdata[9:6], s_tdata[41:10]});
      if (m_tvalid && m_tready) begin
        res_cnt++;
        if (proj_q.size() == 0) report("result with none expected");
        else begin
          e = proj_q.pop_front();
          if (m_tdata[3:0] !== e.comp)
            report($sformatf("component %0d exp %0d", m_tdata[3:0], e.comp));
          if (m_tdata[35:4] !== e.proj)
            report($sformatf("comp %0d value %h exp %h", e.comp, m_tdata[35:4], e.proj));
          if (m_tlast !== e.last) report($sformatf("comp %0d last %b", e.comp, m_tlast));
          if (m_tuser !== e.sat) report($sformatf("comp %0d sat %b", e.comp, m_tuser));
        end
      end
    end else s_took <= 0;
  end

  // driver: change at falling edge
  always @(negedge clk) begin
    load_item_t it;
    bit nv;
    if (rst) begin
      s_tvalid <= 0;
      m_tready <= 0;
      gap = 0;
    end else begin
      m_tready <= cyc[8] ? 1'b1 : ($urandom % 3 != 0);
      nv = s_tvalid && !s_took;
      if (!nv) begin
        if (gap > 0) gap--;
        else if (pend_q.size() > 0) begin
          it = pend_q.pop_front();
          s_tdata <= {6'd0, it.val, it.comp, it.feat};
          s_tuser <= it.op;
          nv = 1;
          if (bursty && $urandom % 5 == 0) gap = $urandom_range(1, 8);
        end
      end
      s_tvalid <= nv;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    wait (pend_q.size() == 0 && !s_tvalid && proj_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(logic [2:0] op, int f, int c, logic [31:0] v);
    pend_q.push_back('{op, f[5:0], c[3:0], v});
    if (op == OP_DATA) data_cnt++;
    else if (op <= OP_WGT) load_cnt++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom % 10)
      0: return $urandom;
      1: return $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
  endfunction

  function automatic logic [31:0] rand_var();
    if ($urandom % 8 == 0) return $urandom;
    return $urandom_range(32'h1000, 32'h80000);
  endfunction

  initial begin
    int n, f, c, target;
    clear_row();
    cen = 0; scl = 0; wht = 0; nfeat = 64; ncomp = 16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    bursty = 1;
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_CENTER, 7'(cfgs[p][0]));
      write_reg(REG_SCALE, 7'(cfgs[p][1]));
      write_reg(REG_WHITEN, 7'(cfgs[p][2]));
      write_reg(REG_NFEAT, 7'(cfgs[p][3]));
      write_reg(REG_NCOMP, 7'(cfgs[p][4]));
      if (p == 0) begin
        // fill every store entry the data items will touch
        foreach (fset[i]) begin
          push(OP_MEAN, fset[i], 0, rand_value());
          push(OP_VAR, fset[i], 0, 32'h0001_0000);
          for (int j = 0; j < MAX_COMPONENTS; j++) push(OP_WGT, fset[i], j, rand_value());
        end
        for (int j = 0; j < MAX_COMPONENTS; j++) push(OP_EIG, 0, j, rand_var());
        // directed corners: extreme means, nonpositive and tiny/huge variances
        push(OP_MEAN, 63, 0, 32'h7FFF_FFFF);
        push(OP_MEAN, 40, 0, 32'h8000_0000);
        push(OP_VAR, 1, 0, 32'h0);
        push(OP_VAR, 2, 0, 32'hFFFF_FFFB);
        push(OP_VAR, 3, 0, 32'h1);
        push(OP_VAR, 4, 0, 32'h7FFF_FFFF);
        push(OP_EIG, 0, 15, 32'h8000_0000);
        push(OP_EIG, 0, 14, 32'h1);
        push(OP_WGT, 63, 15, 32'h7FFF_FFFF);
        push(OP_WGT, 0, 15, 32'h8000_0000);
        push(3'd5, 63, 15, $urandom);
        push(3'd6, 0, 0, $urandom);
        push(3'd7, 40, 9, $urandom);
        push(OP_DATA, 63, 15, 32'h7FFF_FFFF);
        push(OP_DATA, 40, 0, 32'h8000_0000);
        push(OP_DATA, 0, 0, 32'h0);
        push(OP_DATA, 1, 5, 32'h0001_0000);
        push(OP_DATA, 2, 0, 32'hFFFF_0000);
        push(OP_DATA, 3, 0, 32'h0000_8000);
        push(OP_DATA, 4, 0, 32'h7FFF_FFFF);
        push(OP_DATA, 5, 0, 32'h8000_0000);
      end
      target = (cfgs[p][3] >= 64) ? 20 : 12;
      n = 0;
      bursty = (p % 2 == 0);
      while (n < target) begin
        f = fset[$urandom_range(0, 7)];
        c = $urandom_range(0, 15);
        case ($urandom % 10)
          0: push(OP_MEAN, f, c, rand_value());
          1: push(OP_VAR, f, c, rand_var());
          2: push(OP_EIG, f, c, rand_var());
          3: push(OP_WGT, f, c, rand_value());
          4: begin
            push(3'($urandom_range(5, 7)), $urandom, c, $urandom);
            n--;
          end
          default: push(OP_DATA, f, c, rand_value());
        endcase
        n++;
      end
      wait_idle();
    end
    if (proj_q.size() != 0) report($sformatf("%0d results never arrived", proj_q.size()));
    $display("run covered %0d loads, %0d data items, %0d rows over 6 register settings",
             load_cnt, data_cnt, row_cnt);
    $display("%0d results checked, %0d mismatches", res_cnt, err_cnt);
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pca_pkg.sv
hw/rtl/pca_ram.sv
hw/rtl/pca_rsqrt.sv
hw/rtl/pca_projection_engine.sv
hw/rtl/pca_checker.sv
tb/tb_top.sv
